// ===== rtl/dtw_pkg.sv =====
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared sizes, register indexes and state codes for the DTW cost and
// backtrack block.
// ----------------------------------------------------------------------------
package dtw_pkg;

    localparam int REF_MAX   = 64;
    localparam int IN_MAX    = 64;
    localparam int ROW_W     = $clog2(REF_MAX);
    localparam int COL_W     = $clog2(IN_MAX);
    localparam int DEPTH     = REF_MAX * IN_MAX;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COST_W    = 32;
    localparam int DIST_W    = 16;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_LEN  = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_EMIT,
        S_STEP,
        S_RD_D,
        S_RD_U,
        S_DEC
    } t_state;

    typedef enum logic [1:0] {
        MV_LEFT,
        MV_DIAG,
        MV_UP
    } t_move;

endpackage

// ===== rtl/dtw_ram.sv =====
// ----------------------------------------------------------------------------
// dtw_ram
// Generic simple dual-port RAM: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module dtw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dtw_cost_and_backtrack.sv =====
// ----------------------------------------------------------------------------
// dtw_cost_and_backtrack
// Dynamic time warping: accumulated cost matrix in RAM and warping path
// backtrack from the far corner.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one local distance word
//   per matrix cell, row-major: reference rows by input columns. Each cell
//   first reads the upper cost from the cost RAM, then forms the minimum,
//   does the saturating add and writes back, with the input stalled. Left
//   and diagonal costs are held in registers; only the upper cost is read.
//   Output channel (o_out_valid / i_out_stall) carries path words
//   (column, ref_row, last) after the last cell of the matrix, columns in
//   descending order, last set on column 0. At row 0 the walk moves left;
//   elsewhere it reads the left, diagonal and upper costs one at a time
//   from the RAM and steps toward the least, emitting a word on each
//   left or diagonal step.
//   The input is stalled during the walk.
//   A stalled output word holds in the output register; the walk waits.
//   Config writes (ref_len, in_len) restart the matrix; write only when idle.
//   Reset clears control state and lengths to 64; the cost RAM is not
//   cleared; every cost that is used is written earlier in the same matrix.
// ----------------------------------------------------------------------------
module dtw_cost_and_backtrack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtw_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dtw_pkg::DIST_W-1:0]    i_local_dist,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dtw_pkg::POS_W-1:0]     o_column,
    output logic [dtw_pkg::POS_W-1:0]     o_ref_row,
    output logic                          o_last
);

    localparam int ROW_W  = dtw_pkg::ROW_W;
    localparam int COL_W  = dtw_pkg::COL_W;
    localparam int ADDR_W = dtw_pkg::ADDR_W;
    localparam int COST_W = dtw_pkg::COST_W;
    localparam int POS_W  = dtw_pkg::POS_W;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(dtw_pkg::IN_MAX)) + ADDR_W'(c);
    endfunction

    dtw_pkg::t_state r_state, n_state;
    dtw_pkg::t_move  r_move,  n_move;

    logic [dtw_pkg::LEN_W-1:0]  r_ref_len, n_ref_len;
    logic [dtw_pkg::LEN_W-1:0]  r_in_len,  n_in_len;
    logic [ROW_W-1:0]           r_row, n_row;
    logic [COL_W-1:0]           r_col, n_col;
    logic [dtw_pkg::DIST_W-1:0] r_dist, n_dist;
    logic [COST_W-1:0]          r_left, n_left;
    logic [COST_W-1:0]          r_diag, n_diag;
    logic [COST_W-1:0]          r_best, n_best;
    logic [ROW_W-1:0]           r_by, n_by;
    logic [COL_W-1:0]           r_bx, n_bx;
    logic                       r_out_valid, n_out_valid;
    logic [POS_W-1:0]           r_out_col, n_out_col;
    logic [POS_W-1:0]           r_out_row, n_out_row;
    logic                       r_out_last, n_out_last;

    logic [ROW_W-1:0]  row_last;
    logic [COL_W-1:0]  col_last;
    logic              in_acc;
    logic              out_free;
    logic [COST_W-1:0] prev;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cost;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [COST_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [COST_W-1:0] ram_rdata;

    dtw_ram #(
        .WIDTH (COST_W),
        .DEPTH (dtw_pkg::DEPTH)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_ref_len == '0) begin
            row_last = '0;
        end else if (int'(r_ref_len) > dtw_pkg::REF_MAX) begin
            row_last = ROW_W'(dtw_pkg::REF_MAX - 1);
        end else begin
            row_last = ROW_W'(r_ref_len - 7'd1);
        end
        if (r_in_len == '0) begin
            col_last = '0;
        end else if (int'(r_in_len) > dtw_pkg::IN_MAX) begin
            col_last = COL_W'(dtw_pkg::IN_MAX - 1);
        end else begin
            col_last = COL_W'(r_in_len - 7'd1);
        end
    end

    assign o_in_stall = (r_state != dtw_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // cell cost: distance plus least neighbor, saturating
    always_comb begin
        if (r_row != '0 && r_col != '0) begin
            prev = r_diag;
            if (ram_rdata < prev) begin
                prev = ram_rdata;
            end
            if (r_left < prev) begin
                prev = r_left;
            end
        end else if (r_row != '0) begin
            prev = ram_rdata;
        end else if (r_col != '0) begin
            prev = r_left;
        end else begin
            prev = '0;
        end
        sum  = {1'b0, prev} + (COST_W + 1)'(r_dist);
        cost = sum[COST_W] ? '1 : sum[COST_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_move      = r_move;
        n_ref_len   = r_ref_len;
        n_in_len    = r_in_len;
        n_row       = r_row;
        n_col       = r_col;
        n_dist      = r_dist;
        n_left      = r_left;
        n_diag      = r_diag;
        n_best      = r_best;
        n_by        = r_by;
        n_bx        = r_bx;
        n_out_valid = r_out_valid;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = cell_addr(r_row, r_col);
        ram_wdata   = cost;
        ram_re      = 1'b0;
        ram_raddr   = cell_addr(ROW_W'(r_row - 1'b1), r_col);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            dtw_pkg::S_IDLE: begin
                if (in_acc) begin
                    ram_re  = 1'b1;
                    n_dist  = i_local_dist;
                    n_state = dtw_pkg::S_CELL;
                end
            end
            dtw_pkg::S_CELL: begin
                ram_we  = 1'b1;
                n_left  = cost;
                n_diag  = ram_rdata;
                n_state = dtw_pkg::S_IDLE;
                if (r_col == col_last) begin
                    n_col = '0;
                    if (r_row == row_last) begin
                        n_row   = '0;
                        n_bx    = col_last;
                        n_by    = row_last;
                        n_state = dtw_pkg::S_EMIT;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            dtw_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_col   = POS_W'(r_bx);
                    n_out_row   = POS_W'(r_by);
                    n_out_last  = (r_bx == '0);
                    n_state     = dtw_pkg::S_STEP;
                end
            end
            dtw_pkg::S_STEP: begin
                if (r_bx == '0) begin
                    n_state = dtw_pkg::S_IDLE;
                end else if (r_by == '0) begin
                    n_bx    = r_bx - 1'b1;
                    n_state = dtw_pkg::S_EMIT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = cell_addr(r_by, COL_W'(r_bx - 1'b1));
                    n_state   = dtw_pkg::S_RD_D;
                end
            end
            dtw_pkg::S_RD_D: begin
                n_best    = ram_rdata;
                n_move    = dtw_pkg::MV_LEFT;
                ram_re    = 1'b1;
                ram_raddr = cell_addr(ROW_W'(r_by - 1'b1), COL_W'(r_bx - 1'b1));
                n_state   = dtw_pkg::S_RD_U;
            end
            dtw_pkg::S_RD_U: begin
                if (ram_rdata < r_best) begin
                    n_best = ram_rdata;
                    n_move = dtw_pkg::MV_DIAG;
                end
                ram_re    = 1'b1;
                ram_raddr = cell_addr(ROW_W'(r_by - 1'b1), r_bx);
                n_state   = dtw_pkg::S_DEC;
            end
            dtw_pkg::S_DEC: begin
                if (ram_rdata < r_best) begin
                    n_by    = r_by - 1'b1;
                    n_state = dtw_pkg::S_STEP;
                end else if (r_move == dtw_pkg::MV_DIAG) begin
                    n_by    = r_by - 1'b1;
                    n_bx    = r_bx - 1'b1;
                    n_state = dtw_pkg::S_EMIT;
                end else begin
                    n_bx    = r_bx - 1'b1;
                    n_state = dtw_pkg::S_EMIT;
                end
            end
            default: begin
                n_state = dtw_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtw_pkg::CFG_REF_LEN: n_ref_len = i_cfg_data;
                dtw_pkg::CFG_IN_LEN:  n_in_len  = i_cfg_data;
                default:              n_ref_len = r_ref_len;
            endcase
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtw_pkg::S_IDLE;
            r_ref_len   <= dtw_pkg::LEN_RESET;
            r_in_len    <= dtw_pkg::LEN_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref_len   <= n_ref_len;
            r_in_len    <= n_in_len;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_move     <= n_move;
        r_dist     <= n_dist;
        r_left     <= n_left;
        r_diag     <= n_diag;
        r_best     <= n_best;
        r_by       <= n_by;
        r_bx       <= n_bx;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_column    = r_out_col;
    assign o_ref_row   = r_out_row;
    assign o_last      = r_out_last;

    logic bt_active;
    assign bt_active = (r_state == dtw_pkg::S_EMIT) || (r_state == dtw_pkg::S_STEP) ||
                       (r_state == dtw_pkg::S_RD_D) || (r_state == dtw_pkg::S_RD_U) ||
                       (r_state == dtw_pkg::S_DEC);

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= row_last)
        else $error("fill row beyond matrix");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= col_last)
        else $error("fill column beyond matrix");

    a_cell_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtw_pkg::S_CELL) |-> $past(in_acc))
        else $error("cell update without accepted word");

    a_walk_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bt_active && $past(bt_active)) |-> (r_bx <= $past(r_bx)))
        else $error("backtrack column moved right");

endmodule
